// ----- rtl/ren_pkg.sv -----
// ----------------------------------------------------------------------------
// ren_pkg
// Shared widths, constants and controller/datapath interface types for the
// response energy normalizer.
// ----------------------------------------------------------------------------
package ren_pkg;

    localparam int unsigned MAX_SAMPLES = 32768;
    localparam int unsigned ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int unsigned CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int unsigned SAMPLE_W    = 16;
    localparam int unsigned CFG_W       = 15;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned SQ_W        = 31;
    localparam int unsigned ENERGY_W    = 46;
    localparam int unsigned ROOT_W      = 23;
    localparam int unsigned NUM_W       = 30;
    localparam int unsigned DIV_CNT_W   = 5;

    // Highest even bit position of the energy word seeds the root search.
    localparam logic [ENERGY_W-1:0] SQRT_B0 = {{(ENERGY_W-1){1'b0}}, 1'b1} << 44;

    localparam logic [CFG_W-1:0] RMS_TARGET_RST = 15'd16384;
    localparam logic [CFG_W-1:0] PEAK_LIMIT_RST = 15'd32000;

    localparam logic [CFG_IDX_W-1:0] CFG_RMS_TARGET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_LIMIT = 2'd1;

    typedef struct packed {
        logic load;         // store one sample, square it
        logic acc_add;      // add the registered square to the energy
        logic read;         // take one read transaction
        logic out_load;     // move the read result into the output register
        logic sqrt_start;
        logic sqrt_step;
        logic pass_begin;
        logic pass_sel;     // 0 energy scaling pass, 1 peak limiting pass
        logic mem_rd;       // fetch the sample at the pass index
        logic mul;
        logic div_start;
        logic pass_write;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic sqrt_done;
        logic root_zero;
        logic count_zero;
        logic div_done;
        logic idx_last;
        logic peak_over;
        logic pass_second;
    } t_sts;

endpackage

// ----- rtl/ren_div.sv -----
// ----------------------------------------------------------------------------
// ren_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ren_div
    import ren_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [ROOT_W-1:0] i_den,
    output logic [NUM_W-1:0]  o_quo,
    output logic              o_done
);

    logic [DIV_CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0]     r_quo;
    logic [ROOT_W-1:0]    r_rem;
    logic [ROOT_W-1:0]    r_den;
    logic [ROOT_W:0]      trial;
    logic                 fits;

    assign trial = {r_rem, r_quo[NUM_W-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= DIV_CNT_W'(NUM_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[NUM_W-2:0], fits};
            r_rem <= fits ? ROOT_W'(trial - {1'b0, r_den}) : trial[ROOT_W-1:0];
        end
    end

    assign o_quo  = r_quo;
    assign o_done = (r_cnt == '0);

endmodule

// ----- rtl/ren_dp.sv -----
// ----------------------------------------------------------------------------
// ren_dp
// Datapath: sample memory, energy accumulator, square root, scaling
// multiplier and divider, peak tracking, configuration and output register.
// ----------------------------------------------------------------------------
module ren_dp
    import ren_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    input  logic [SAMPLE_W-1:0]  i_sample,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [SAMPLE_W-1:0]  o_out_sample,
    output logic                 o_out_last,
    output logic                 o_out_status
);

    function automatic logic [SAMPLE_W-1:0] clamp_signed(input logic [NUM_W-1:0] q,
                                                         input logic neg);
        logic [SAMPLE_W-1:0] res;
        if (neg) begin
            res = (q > NUM_W'(32768)) ? 16'h8000 : SAMPLE_W'(~q + 1'b1);
        end else begin
            res = (q > NUM_W'(32767)) ? 16'h7FFF : q[SAMPLE_W-1:0];
        end
        return res;
    endfunction

    function automatic logic [SAMPLE_W-1:0] clamp_mag(input logic [NUM_W-1:0] q,
                                                      input logic neg);
        logic [SAMPLE_W-1:0] res;
        if (neg) begin
            res = (q > NUM_W'(32768)) ? 16'd32768 : q[SAMPLE_W-1:0];
        end else begin
            res = (q > NUM_W'(32767)) ? 16'd32767 : q[SAMPLE_W-1:0];
        end
        return res;
    endfunction

    logic [SAMPLE_W-1:0] r_mem [MAX_SAMPLES];
    logic [SAMPLE_W-1:0] r_rdata;

    logic [CFG_W-1:0]    r_rms_target;
    logic [CFG_W-1:0]    r_peak_limit;

    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_rp;
    logic                r_set_ready;
    logic [ENERGY_W-1:0] r_energy;
    logic [SQ_W-1:0]     r_sq;

    logic [ENERGY_W-1:0] r_rem;
    logic [ENERGY_W-1:0] r_acc;
    logic [ENERGY_W-1:0] r_b;

    logic [ADDR_W-1:0]   r_idx;
    logic                r_pass;
    logic [SAMPLE_W-1:0] r_peak;
    logic [NUM_W-1:0]    r_prod;
    logic                r_neg;

    logic                r_rd_hit;
    logic                r_rd_fin;

    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_sample;
    logic                r_out_last;
    logic                r_out_status;

    logic [CNT_W-1:0]    load_base;
    logic                load_ok;
    logic signed [2*SAMPLE_W-1:0] sq_full;
    logic                rd_hit;
    logic                rd_fin;
    logic [ENERGY_W-1:0] sqrt_trial;
    logic [SAMPLE_W-1:0] mag;
    logic [CFG_W-1:0]    factor;
    logic [SAMPLE_W+CFG_W-1:0] prod_full;
    logic [ROOT_W-1:0]   den;
    logic [NUM_W-1:0]    quo;
    logic                div_done;
    logic [SAMPLE_W-1:0] scaled;
    logic [SAMPLE_W-1:0] scaled_mag;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [SAMPLE_W-1:0] mem_wdata;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_raddr;

    // A load into a set that is ready starts a fresh set at entry zero.
    assign load_base = r_set_ready ? '0 : r_count;
    assign load_ok   = load_base < CNT_W'(MAX_SAMPLES);
    assign sq_full   = $signed(i_sample) * $signed(i_sample);

    assign rd_hit = r_set_ready && (r_rp < r_count);
    assign rd_fin = (CNT_W'(r_rp + 1'b1) == r_count);

    assign sqrt_trial = r_acc + r_b;

    assign mag       = r_rdata[SAMPLE_W-1] ? SAMPLE_W'(~r_rdata + 1'b1) : r_rdata;
    assign factor    = r_pass ? r_peak_limit : r_rms_target;
    assign prod_full = mag * factor;
    assign den       = r_pass ? ROOT_W'(r_peak) : r_acc[ROOT_W-1:0];

    ren_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_prod),
        .i_den   (den),
        .o_quo   (quo),
        .o_done  (div_done)
    );

    assign scaled     = clamp_signed(quo, r_neg);
    assign scaled_mag = clamp_mag(quo, r_neg);

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = scaled;
        if (i_cmd.load) begin
            mem_we    = load_ok;
            mem_waddr = load_base[ADDR_W-1:0];
            mem_wdata = i_sample;
        end else if (i_cmd.pass_write) begin
            mem_we = 1'b1;
        end
    end

    assign mem_re    = i_cmd.mem_rd | (i_cmd.read & rd_hit);
    assign mem_raddr = i_cmd.read ? r_rp[ADDR_W-1:0] : r_idx;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rms_target <= RMS_TARGET_RST;
            r_peak_limit <= PEAK_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RMS_TARGET: r_rms_target <= i_cfg_data;
                CFG_PEAK_LIMIT: r_peak_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Set bookkeeping: count, read pointer, ready flag and energy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rp        <= '0;
            r_set_ready <= 1'b0;
            r_energy    <= '0;
        end else if (i_cmd.load) begin
            r_count     <= load_base + CNT_W'(load_ok);
            r_rp        <= r_set_ready ? '0 : r_rp;
            r_set_ready <= 1'b0;
            r_energy    <= r_set_ready ? '0 : r_energy;
        end else if (i_cmd.acc_add) begin
            r_energy <= r_energy + ENERGY_W'(r_sq);
        end else if (i_cmd.read) begin
            if (rd_hit && rd_fin) begin
                r_count     <= '0;
                r_rp        <= '0;
                r_set_ready <= 1'b0;
                r_energy    <= '0;
            end else if (rd_hit) begin
                r_rp <= r_rp + 1'b1;
            end else begin
                r_set_ready <= 1'b0;
            end
        end else if (i_cmd.finish) begin
            r_rp        <= '0;
            r_set_ready <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sq <= load_ok ? sq_full[SQ_W-1:0] : '0;
        end
    end

    // Square root, two energy bits per step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b <= '0;
        end else if (i_cmd.sqrt_start) begin
            r_b <= SQRT_B0;
        end else if (i_cmd.sqrt_step && (r_b != '0)) begin
            r_b <= r_b >> 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_start) begin
            r_rem <= r_energy;
            r_acc <= '0;
        end else if (i_cmd.sqrt_step && (r_b != '0)) begin
            if (r_rem >= sqrt_trial) begin
                r_rem <= r_rem - sqrt_trial;
                r_acc <= (r_acc >> 1) + r_b;
            end else begin
                r_acc <= r_acc >> 1;
            end
        end
    end

    // Scaling passes.
    always_ff @(posedge i_clk) begin
        if (i_cmd.pass_begin) begin
            r_idx  <= '0;
            r_pass <= i_cmd.pass_sel;
            if (!i_cmd.pass_sel) begin
                r_peak <= SAMPLE_W'(1);
            end
        end else if (i_cmd.pass_write) begin
            r_idx <= r_idx + 1'b1;
            if (!r_pass && (scaled_mag > r_peak)) begin
                r_peak <= scaled_mag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= prod_full[NUM_W-1:0];
            r_neg  <= r_rdata[SAMPLE_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_rd_hit <= rd_hit;
            r_rd_fin <= rd_fin;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_sample <= r_rd_hit ? r_rdata : '0;
            r_out_last   <= r_rd_hit & r_rd_fin;
            r_out_status <= ~r_rd_hit;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_sample = r_out_sample;
    assign o_out_last   = r_out_last;
    assign o_out_status = r_out_status;

    assign o_sts.out_free    = ~r_out_valid | i_out_ready;
    assign o_sts.sqrt_done   = (r_b == '0);
    assign o_sts.root_zero   = (r_acc == '0);
    assign o_sts.count_zero  = (r_count == '0);
    assign o_sts.div_done    = div_done;
    assign o_sts.idx_last    = (CNT_W'({1'b0, r_idx} + 1'b1) == r_count);
    assign o_sts.peak_over   = (r_peak > SAMPLE_W'(r_peak_limit));
    assign o_sts.pass_second = r_pass;

endmodule

// ----- rtl/ren_ctrl.sv -----
// ----------------------------------------------------------------------------
// ren_ctrl
// Controller: sequences loads, reads, the root search and the scaling passes.
// ----------------------------------------------------------------------------
module ren_ctrl
    import ren_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_mode,
    input  logic i_in_last,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_LACC = 11'b000_0000_0010,
        S_SQST = 11'b000_0000_0100,
        S_SQRT = 11'b000_0000_1000,
        S_PRD  = 11'b000_0001_0000,
        S_PMUL = 11'b000_0010_0000,
        S_PDST = 11'b000_0100_0000,
        S_PDW  = 11'b000_1000_0000,
        S_PWR  = 11'b001_0000_0000,
        S_PCHK = 11'b010_0000_0000,
        S_RDAT = 11'b100_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_last;

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_IDLE) && i_in_valid && !i_in_mode) begin
                r_last <= i_in_last;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_mode) begin
                        o_cmd.read = 1'b1;
                        n_state    = S_RDAT;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state    = S_LACC;
                    end
                end
            end
            S_LACC: begin
                o_cmd.acc_add = 1'b1;
                n_state       = r_last ? S_SQST : S_IDLE;
            end
            S_SQST: begin
                o_cmd.sqrt_start = 1'b1;
                n_state          = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (i_sts.sqrt_done) begin
                    if (i_sts.root_zero || i_sts.count_zero) begin
                        o_cmd.finish = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        o_cmd.pass_begin = 1'b1;
                        n_state          = S_PRD;
                    end
                end
            end
            S_PRD: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = S_PMUL;
            end
            S_PMUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_PDST;
            end
            S_PDST: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_PDW;
            end
            S_PDW: begin
                if (i_sts.div_done) begin
                    n_state = S_PWR;
                end
            end
            S_PWR: begin
                o_cmd.pass_write = 1'b1;
                if (!i_sts.idx_last) begin
                    n_state = S_PRD;
                end else if (i_sts.pass_second) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_PCHK;
                end
            end
            S_PCHK: begin
                if (i_sts.peak_over) begin
                    o_cmd.pass_begin = 1'b1;
                    o_cmd.pass_sel   = 1'b1;
                    n_state          = S_PRD;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_RDAT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/response_energy_normalizer.sv -----
// ----------------------------------------------------------------------------
// response_energy_normalizer
// Loads a run of impulse samples, normalizes them to a target level of the
// root sum of squares with a peak limit, and returns them on request.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream carries one command per transaction. With s_axis_tuser low
// the transaction loads s_axis_tdata as a sample; s_axis_tlast on a load ends
// the set and starts normalization. With s_axis_tuser high the transaction
// asks for the next normalized sample, and exactly one result transaction
// follows on the master stream: the sample, m_axis_tlast on the final one,
// and m_axis_tuser high when no normalized set is ready (data then reads 0).
// A read waits while the output register stays full. After the last load
// the block computes the root of the energy and runs one scaling pass over
// the samples, and a second pass when the peak limit applies; each sample
// goes through the divider in every pass.
// s_axis_tready is high only while the controller is idle, so a stalled
// master side holds back at most one read beyond the result waiting in the
// output register. Reset clears all control state and returns the
// configuration registers to their defaults; the sample memory is not cleared.
// Configuration writes are taken at any time and must be issued while idle.
// ----------------------------------------------------------------------------
module response_energy_normalizer
    import ren_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Sample and read commands.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [SAMPLE_W-1:0]  s_axis_tdata,   // [15:0] sample_in
    input  logic                 s_axis_tlast,   // last_in
    input  logic                 s_axis_tuser,   // [0] mode
    // Normalized sample results.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [SAMPLE_W-1:0]  m_axis_tdata,   // [15:0] sample_out
    output logic                 m_axis_tlast,   // last_out
    output logic                 m_axis_tuser,   // [0] status
    // Configuration writes.
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    // The register file takes a write in any cycle.
    assign o_cfg_ready = 1'b1;

    ren_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_mode  (s_axis_tuser),
        .i_in_last  (s_axis_tlast),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ren_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_sample     (s_axis_tdata),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_sample (m_axis_tdata),
        .o_out_last   (m_axis_tlast),
        .o_out_status (m_axis_tuser)
    );

endmodule
